### hw/rtl/jaie_pkg.sv
package jaie_pkg;

    // Field and datapath widths
    localparam int unsigned SCALE_W   = 11;
    localparam int unsigned PTR_W     = 10;
    localparam int unsigned ACCEL_W   = 10;
    localparam int unsigned STICK_W   = 8;
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;

    // Largest pointer value; quotients above it saturate
    localparam logic [PTR_W-1:0] PTR_MAX = 10'd1023;

    // Direction and key codes
    localparam logic [CODE_W-1:0] DIR_NONE  = 8'h00;
    localparam logic [CODE_W-1:0] DIR_LEFT  = 8'h40;
    localparam logic [CODE_W-1:0] DIR_RIGHT = 8'h80;
    localparam logic [CODE_W-1:0] DIR_DOWN  = 8'h20;
    localparam logic [CODE_W-1:0] DIR_UP    = 8'h10;
    localparam logic [CODE_W-1:0] KEY_NONE  = 8'h00;
    localparam logic [CODE_W-1:0] KEY_ENTER = 8'h0d;

    // Stick positions
    localparam logic [STICK_W-1:0] STICK_LOW    = 8'd0;
    localparam logic [STICK_W-1:0] STICK_HIGH   = 8'd255;
    localparam logic [STICK_W-1:0] STICK_CENTER = 8'd128;

    // Reset values
    localparam logic [SCALE_W-1:0] WIDTH_RESET   = 11'd320;
    localparam logic [SCALE_W-1:0] HEIGHT_RESET  = 11'd240;
    localparam int unsigned        LEAST_NOMINAL = 1000;

    typedef enum logic [1:0] {
        EV_DIRECTION = 2'd0,
        EV_KEY       = 2'd1,
        EV_POINTER   = 2'd2
    } event_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

### hw/rtl/joystick_accel_to_input_events.sv
// Controller sample to input events.
// Slave stream (s_*): one polled sample per transfer: stick X/Y, Z button and
// two accelerometer axes. Master stream (m_*): one to three events per sample,
// in order direction change, key change, pointer update; m_tlast marks the
// pointer event, which closes every sample. m_tuser carries the event kind.
// Config channel (cfg_*): register 0 screen width, 1 screen height; always
// ready, to be written only while no sample is in flight.
// Pointer path: the pointer event is computed by two bit-serial scale units
// (one per axis), each a shift-add multiply followed by a restoring divide.
// A sample is accepted and the units start in the cycle after; when both
// are done, the pointer event is loaded into the output register once no
// direction or key event waits and the output slot is free. The next sample
// is accepted only after that, so samples never overlap in the units.
// Direction and key events leave while the units are still working.
// A single output register parts the sides: a stalled receiver holds events
// there, and a new sample can be taken while the pointer event still waits.
// Reset: latches and codes clear, calibration returns to its initial range,
// screen size returns to 320 x 240.
module joystick_accel_to_input_events #(
    parameter int unsigned ACCEL_BITS = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // stick_x[7:0], stick_y[15:8], button_z[16], accel_x[26:17],
    // accel_z[36:27], zero pad[39:37]
    input  logic [39:0]                        s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // direction_byte[7:0], key_byte[15:8], pointer_x[25:16],
    // pointer_y[35:26], zero pad[39:36]
    output logic [39:0]                        m_tdata,
    // event_kind[1:0]
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [jaie_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jaie_pkg::SCALE_W-1:0]       cfg_data
);

    localparam int unsigned AB       = ACCEL_BITS;
    localparam int unsigned AccMax   = (1 << ACCEL_BITS) - 1;
    localparam logic [AB-1:0] LeastReset =
        AB'((AccMax < jaie_pkg::LEAST_NOMINAL) ? AccMax : jaie_pkg::LEAST_NOMINAL);
    localparam logic [AB-1:0] GreatestReset = AB'(1);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    // Input field unpack
    logic [jaie_pkg::STICK_W-1:0] in_sx, in_sy;
    logic                         in_bz;
    logic [AB-1:0]                in_ax, in_az;
    logic                         s_accept;

    assign in_sx    = s_tdata[7:0];
    assign in_sy    = s_tdata[15:8];
    assign in_bz    = s_tdata[16];
    assign in_ax    = AB'(s_tdata[26:17]);
    assign in_az    = AB'(s_tdata[36:27]);
    assign s_accept = s_tvalid && s_tready;

    // Control state
    state_t state_reg, state_next;
    logic   start_reg, start_next;
    logic   dir_pend_reg, dir_pend_next;
    logic   key_pend_reg, key_pend_next;
    logic   stick_latched_reg, stick_latched_next;
    logic   key_latched_reg, key_latched_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic [jaie_pkg::CODE_W-1:0]  dir_val_reg, dir_val_next;
    logic [jaie_pkg::CODE_W-1:0]  key_val_reg, key_val_next;
    logic [jaie_pkg::SCALE_W-1:0] width_reg, width_next;
    logic [jaie_pkg::SCALE_W-1:0] height_reg, height_next;
    logic [AB-1:0] least_x_reg, least_x_next, greatest_x_reg, greatest_x_next;
    logic [AB-1:0] least_z_reg, least_z_next, greatest_z_reg, greatest_z_next;

    // Payload
    logic [AB-1:0]                ax_reg, ax_next, az_reg, az_next;
    logic [jaie_pkg::CODE_W-1:0]  key_for_dir_reg, key_for_dir_next;
    jaie_pkg::event_kind_t        m_kind_reg, m_kind_next;
    logic                         m_last_reg, m_last_next;
    logic [jaie_pkg::CODE_W-1:0]  m_dir_reg, m_dir_next, m_key_reg, m_key_next;
    logic [jaie_pkg::PTR_W-1:0]   m_px_reg, m_px_next, m_py_reg, m_py_next;

    // Scale units
    logic                       busy_x, busy_y;
    logic [jaie_pkg::PTR_W-1:0] res_x, res_y;
    logic [AB-1:0]              num_x, num_z;
    logic [AB:0]                den_x, den_z;

    // Min/max are updated at the input transfer, so the sample lies within range
    assign num_x = ax_reg - least_x_reg;
    assign num_z = az_reg - least_z_reg;
    assign den_x = {1'b0, greatest_x_reg} - {1'b0, least_x_reg} + 1'b1;
    assign den_z = {1'b0, greatest_z_reg} - {1'b0, least_z_reg} + 1'b1;

    jaie_scale #(.ACCEL_BITS(ACCEL_BITS)) u_scale_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .scale   (width_reg),
        .num     (num_x),
        .den     (den_x),
        .busy    (busy_x),
        .result  (res_x)
    );

    jaie_scale #(.ACCEL_BITS(ACCEL_BITS)) u_scale_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .scale   (height_reg),
        .num     (num_z),
        .den     (den_z),
        .busy    (busy_y),
        .result  (res_y)
    );

    // Output slot handling
    logic out_free, ptr_ready, load_dir, load_key, load_ptr;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign ptr_ready = !start_reg && !busy_x && !busy_y;
    assign load_dir  = (state_reg == ST_RUN) && out_free && dir_pend_reg;
    assign load_key  = (state_reg == ST_RUN) && out_free && !dir_pend_reg && key_pend_reg;
    assign load_ptr  = (state_reg == ST_RUN) && out_free && !dir_pend_reg &&
                       !key_pend_reg && ptr_ready;

    always_comb begin
        state_next         = state_reg;
        start_next         = 1'b0;
        dir_pend_next      = dir_pend_reg;
        key_pend_next      = key_pend_reg;
        stick_latched_next = stick_latched_reg;
        key_latched_next   = key_latched_reg;
        dir_val_next       = dir_val_reg;
        key_val_next       = key_val_reg;
        width_next         = width_reg;
        height_next        = height_reg;
        least_x_next       = least_x_reg;
        greatest_x_next    = greatest_x_reg;
        least_z_next       = least_z_reg;
        greatest_z_next    = greatest_z_reg;
        ax_next            = ax_reg;
        az_next            = az_reg;
        key_for_dir_next   = key_for_dir_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        m_kind_next        = m_kind_reg;
        m_last_next        = m_last_reg;
        m_dir_next         = m_dir_reg;
        m_key_next         = m_key_reg;
        m_px_next          = m_px_reg;
        m_py_next          = m_py_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                jaie_pkg::REG_SCREEN_WIDTH:  width_next  = cfg_data;
                jaie_pkg::REG_SCREEN_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        if (s_accept) begin
            state_next = ST_RUN;
            start_next = 1'b1;
            ax_next    = in_ax;
            az_next    = in_az;

            // stick: extreme while unlatched, or back to center while latched
            if (!stick_latched_reg) begin
                if (in_sx == jaie_pkg::STICK_LOW) begin
                    dir_val_next = jaie_pkg::DIR_LEFT;
                end else if (in_sx == jaie_pkg::STICK_HIGH) begin
                    dir_val_next = jaie_pkg::DIR_RIGHT;
                end else if (in_sy == jaie_pkg::STICK_LOW) begin
                    dir_val_next = jaie_pkg::DIR_DOWN;
                end else if (in_sy == jaie_pkg::STICK_HIGH) begin
                    dir_val_next = jaie_pkg::DIR_UP;
                end
                if (in_sx == jaie_pkg::STICK_LOW || in_sx == jaie_pkg::STICK_HIGH ||
                    in_sy == jaie_pkg::STICK_LOW || in_sy == jaie_pkg::STICK_HIGH) begin
                    stick_latched_next = 1'b1;
                    dir_pend_next      = 1'b1;
                end
            end else if (in_sx == jaie_pkg::STICK_CENTER &&
                         in_sy == jaie_pkg::STICK_CENTER) begin
                dir_val_next       = jaie_pkg::DIR_NONE;
                stick_latched_next = 1'b0;
                dir_pend_next      = 1'b1;
            end

            // direction event reports the key code from before this sample
            key_for_dir_next = key_val_reg;
            if (!key_latched_reg && in_bz) begin
                key_val_next     = jaie_pkg::KEY_ENTER;
                key_latched_next = 1'b1;
                key_pend_next    = 1'b1;
            end else if (key_latched_reg && !in_bz) begin
                key_val_next     = jaie_pkg::KEY_NONE;
                key_latched_next = 1'b0;
                key_pend_next    = 1'b1;
            end

            // running calibration
            if (in_ax < least_x_reg)    least_x_next    = in_ax;
            if (in_ax > greatest_x_reg) greatest_x_next = in_ax;
            if (in_az < least_z_reg)    least_z_next    = in_az;
            if (in_az > greatest_z_reg) greatest_z_next = in_az;
        end

        if (load_dir) begin
            dir_pend_next = 1'b0;
            m_tvalid_next = 1'b1;
            m_kind_next   = jaie_pkg::EV_DIRECTION;
            m_last_next   = 1'b0;
            m_dir_next    = dir_val_reg;
            m_key_next    = key_for_dir_reg;
            m_px_next     = '0;
            m_py_next     = '0;
        end else if (load_key) begin
            key_pend_next = 1'b0;
            m_tvalid_next = 1'b1;
            m_kind_next   = jaie_pkg::EV_KEY;
            m_last_next   = 1'b0;
            m_dir_next    = dir_val_reg;
            m_key_next    = key_val_reg;
            m_px_next     = '0;
            m_py_next     = '0;
        end else if (load_ptr) begin
            state_next    = ST_IDLE;
            m_tvalid_next = 1'b1;
            m_kind_next   = jaie_pkg::EV_POINTER;
            m_last_next   = 1'b1;
            m_dir_next    = dir_val_reg;
            m_key_next    = key_val_reg;
            m_px_next     = res_x;
            m_py_next     = res_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            start_reg         <= 1'b0;
            dir_pend_reg      <= 1'b0;
            key_pend_reg      <= 1'b0;
            stick_latched_reg <= 1'b0;
            key_latched_reg   <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            dir_val_reg       <= jaie_pkg::DIR_NONE;
            key_val_reg       <= jaie_pkg::KEY_NONE;
            width_reg         <= jaie_pkg::WIDTH_RESET;
            height_reg        <= jaie_pkg::HEIGHT_RESET;
            least_x_reg       <= LeastReset;
            greatest_x_reg    <= GreatestReset;
            least_z_reg       <= LeastReset;
            greatest_z_reg    <= GreatestReset;
        end else begin
            state_reg         <= state_next;
            start_reg         <= start_next;
            dir_pend_reg      <= dir_pend_next;
            key_pend_reg      <= key_pend_next;
            stick_latched_reg <= stick_latched_next;
            key_latched_reg   <= key_latched_next;
            m_tvalid_reg      <= m_tvalid_next;
            dir_val_reg       <= dir_val_next;
            key_val_reg       <= key_val_next;
            width_reg         <= width_next;
            height_reg        <= height_next;
            least_x_reg       <= least_x_next;
            greatest_x_reg    <= greatest_x_next;
            least_z_reg       <= least_z_next;
            greatest_z_reg    <= greatest_z_next;
        end
    end

    always_ff @(posedge aclk) begin
        ax_reg          <= ax_next;
        az_reg          <= az_next;
        key_for_dir_reg <= key_for_dir_next;
        m_kind_reg      <= m_kind_next;
        m_last_reg      <= m_last_next;
        m_dir_reg       <= m_dir_next;
        m_key_reg       <= m_key_next;
        m_px_reg        <= m_px_next;
        m_py_reg        <= m_py_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = m_last_reg;
    assign m_tuser   = m_kind_reg;
    assign m_tdata   = {4'b0000, m_py_reg, m_px_reg, m_key_reg, m_dir_reg};

`ifndef SYNTH
    // a new sample is only taken once both scale units are free
    a_idle_units_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!busy_x && !busy_y && !start_reg))
        else $error("sample accepted while scale units busy");

    // the pointer event never overtakes a pending direction or key event
    a_ptr_after_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        load_ptr |-> (!dir_pend_reg && !key_pend_reg))
        else $error("pointer event ahead of pending event");

    // tlast marks exactly the pointer event
    a_last_is_pointer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == jaie_pkg::EV_POINTER)))
        else $error("tlast does not match pointer event");

    // an input transfer starts both scale units on the following cycle
    a_start_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (start_reg && !busy_x && !busy_y))
        else $error("scale units not started after transfer");
`endif

endmodule

### hw/rtl/jaie_scale.sv
// Bit-serial scale unit: result = min(scale * num / den, PTR_MAX).
// MSB-first shift-add multiply, then restoring division, one bit per cycle.
// Requires num < den.
module jaie_scale #(
    parameter int unsigned ACCEL_BITS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [jaie_pkg::SCALE_W-1:0]      scale,
    input  logic [ACCEL_BITS-1:0]             num,
    input  logic [ACCEL_BITS:0]               den,
    output logic                              busy,
    output logic [jaie_pkg::PTR_W-1:0]        result
);

    localparam int unsigned SW   = jaie_pkg::SCALE_W;
    localparam int unsigned W    = SW + ACCEL_BITS;
    localparam int unsigned CntW = $clog2(SW);
    localparam logic [CntW-1:0] CntLast = CntW'(SW - 1);

    typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV} ustate_t;

    ustate_t               state_reg, state_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic [W-1:0]          acc_reg, acc_next;
    logic [SW-1:0]         mr_reg, mr_next;
    logic [ACCEL_BITS-1:0] num_reg, num_next;
    logic [ACCEL_BITS:0]   den_reg, den_next;
    logic [ACCEL_BITS-1:0] rem_reg, rem_next;

    logic [W-1:0]          mul_sum;
    logic [ACCEL_BITS:0]   trial;
    logic [ACCEL_BITS:0]   diff;
    logic                  ge;
    logic [SW-1:0]         quot;

    assign mul_sum = {acc_reg[W-2:0], 1'b0} + (mr_reg[SW-1] ? W'(num_reg) : '0);
    assign trial   = {rem_reg, acc_reg[SW-1]};
    assign ge      = (trial >= den_reg);
    assign diff    = trial - den_reg;
    assign quot    = acc_reg[SW-1:0];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mr_next    = mr_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        case (state_reg)
            U_IDLE: begin
                if (start) begin
                    num_next   = num;
                    den_next   = den;
                    mr_next    = scale;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = U_MUL;
                end
            end
            U_MUL: begin
                acc_next = mul_sum;
                mr_next  = {mr_reg[SW-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntLast) begin
                    // top bits of the product are already below den
                    rem_next   = mul_sum[W-1:SW];
                    cnt_next   = '0;
                    state_next = U_DIV;
                end
            end
            U_DIV: begin
                rem_next          = ge ? diff[ACCEL_BITS-1:0] : trial[ACCEL_BITS-1:0];
                acc_next[SW-1:0]  = {acc_reg[SW-2:0], ge};
                cnt_next          = cnt_reg + 1'b1;
                if (cnt_reg == CntLast) begin
                    state_next = U_IDLE;
                end
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mr_reg  <= mr_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy   = (state_reg != U_IDLE);
    assign result = (quot > SW'(jaie_pkg::PTR_MAX)) ? jaie_pkg::PTR_MAX
                                                    : quot[jaie_pkg::PTR_W-1:0];

endmodule
